/* rtl/ocbt_pkg.sv */
// Package for the offense count ban table: command codes, queue entry type
// and result type. No dependencies.
`timescale 1ns / 1ps
package ocbt_pkg;

    localparam logic [1:0] CMD_TRACK   = 2'd0;
    localparam logic [1:0] CMD_CHECK   = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_CLEANUP = 2'd3;

    localparam logic [0:0] REG_COUNT_TO_BAN     = 1'b0;
    localparam logic [0:0] REG_SECONDS_TO_UNBAN = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] source_address;
    } ocbt_cmd_t;

    typedef struct packed {
        logic       banned;
        logic       present;
        logic       dropped_full;
        logic [6:0] entries_in_use;
    } ocbt_result_t;

endpackage

/* rtl/offense_count_ban_table_unit.sv */
// Top level of the offense count ban table: front queue plus table engine.
// Depends on ocbt_pkg, ocbt_front and ocbt_back.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries commands: tdata[1:0] cmd (0 track, 1 check, 2 tick,
//   3 cleanup), tdata[33:2] source address. m_axis returns one result per
//   transaction: tdata bit 0 banned, 1 present, 2 dropped_full,
//   bits 9:3 entries in use.
//   cfg_we/cfg_idx/cfg_data write count_to_ban (0) and seconds_to_unban (1);
//   write only while idle.
//   Every command scans the whole table, one entry a cycle through the
//   table memory port, so the length of the scan does not depend on the
//   command or on the table contents. The engine takes the next command in
//   the cycle after its result is accepted, and no new command before then.
//   A two-entry queue lets two further commands be accepted while the engine
//   works. When m_axis_tready is low the result is held and the engine
//   waits; the queue then fills and s_axis_tready drops.
//   Reset clears all entry valid bits, the seconds counter and the
//   registers to 10 and 300; no clearing pass is needed.
module offense_count_ban_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cmd[1:0], source_address[33:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // banned, present, dropped_full, entries_in_use[9:3]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [15:0] cfg_data
);
    import ocbt_pkg::*;

    ocbt_cmd_t    in_cmd, q_cmd;
    ocbt_result_t res;
    logic         q_valid, q_ready;

    assign in_cmd.cmd            = s_axis_tdata[1:0];
    assign in_cmd.source_address = s_axis_tdata[33:2];
    assign m_axis_tdata = {6'd0, res.entries_in_use, res.dropped_full,
                           res.present, res.banned};

    ocbt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ocbt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );
endmodule

/* rtl/ocbt_front.sv */
// Front end: accepts transactions and holds them in a two-entry queue.
// Depends on ocbt_pkg.
`timescale 1ns / 1ps
module ocbt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ocbt_pkg::ocbt_cmd_t in_cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output ocbt_pkg::ocbt_cmd_t q_cmd
);
    import ocbt_pkg::*;

    ocbt_cmd_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'd2) else $error("queue overfill");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && !pop) |=> (fill_reg == 2'd2))
        else $error("full queue lost an entry");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 && !push) |=> !q_valid)
        else $error("entry from empty queue");
endmodule

/* rtl/ocbt_back.sv */
// Back end: scans the table one entry a cycle and carries out each command.
// Depends on ocbt_pkg.
`timescale 1ns / 1ps
module ocbt_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_idx,
    input  logic [15:0]           cfg_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  ocbt_pkg::ocbt_cmd_t   q_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ocbt_pkg::ocbt_result_t out_res
);
    import ocbt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0]        addr_mem [TABLE_DEPTH];
    logic [7:0]         count_mem [TABLE_DEPTH];
    logic [31:0]        stamp_mem [TABLE_DEPTH];
    logic [31:0]        rd_addr_reg, rd_stamp_reg;
    logic [7:0]         rd_count_reg;
    logic [AW-1:0]      idx_reg, rd_idx_reg;
    logic [AW:0]        scan_reg;
    logic               found_reg;
    logic [AW-1:0]      hit_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_reg;
    ocbt_cmd_t          cur_reg;
    logic [31:0]        seconds_reg;
    logic [7:0]         ban_reg;
    logic [15:0]        unban_reg;
    logic [CW-1:0]      used_reg;
    logic [7:0]         hit_count_reg;
    logic [31:0]        hit_stamp_reg;
    logic               out_valid_reg;
    ocbt_result_t       res_reg;
    logic               expired;
    logic               hit_expired;
    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    logic [7:0]         wr_count;
    logic [31:0]        wr_addr;
    logic               wr_addr_en;
    logic [7:0]         bumped;

    assign q_ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_res     = res_reg;
    assign expired     = (seconds_reg - rd_stamp_reg) > {16'd0, unban_reg};
    assign hit_expired = (seconds_reg - hit_stamp_reg) > {16'd0, unban_reg};
    assign bumped      = (hit_count_reg == 8'hFF) ? 8'hFF : hit_count_reg + 8'd1;

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= addr_mem[idx_reg];
        rd_count_reg <= count_mem[idx_reg];
        rd_stamp_reg <= stamp_mem[idx_reg];
        rd_idx_reg   <= idx_reg;
        if (wr_en)
        begin
            count_mem[wr_idx] <= wr_count;
            stamp_mem[wr_idx] <= seconds_reg;
        end
        if (wr_addr_en)
        begin
            addr_mem[wr_idx] <= wr_addr;
        end
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr_en = 1'b0;
        wr_idx     = hit_reg;
        wr_count   = bumped;
        wr_addr    = cur_reg.source_address;
        if (state_reg == ST_APPLY)
        begin
            case (cur_reg.cmd)
                CMD_TRACK:
                begin
                    if (found_reg)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr_en = 1'b1;
                        wr_idx     = free_reg;
                        wr_count   = 8'd1;
                    end
                end
                CMD_CHECK:
                begin
                    wr_en = found_reg && (hit_count_reg == ban_reg) && !hit_expired;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid && q_ready) state_next = ST_READ;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:
                if (scan_reg == (AW+1)'(TABLE_DEPTH)) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            seconds_reg   <= 32'd0;
            ban_reg       <= 8'd10;
            unban_reg     <= 16'd300;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            cur_reg       <= '0;
            hit_reg       <= '0;
            free_reg      <= '0;
            hit_count_reg <= '0;
            hit_stamp_reg <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_idx == REG_COUNT_TO_BAN) ban_reg <= cfg_data[7:0];
                else unban_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        cur_reg        <= q_cmd;
                        idx_reg        <= '0;
                        scan_reg       <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
                ST_EVAL:
                begin
                    if (scan_reg < (AW+1)'(TABLE_DEPTH))
                    begin
                        idx_reg  <= idx_reg + AW'(1);
                        scan_reg <= scan_reg + (AW+1)'(1);
                        if (valid_reg[rd_idx_reg])
                        begin
                            if (!found_reg && rd_addr_reg == cur_reg.source_address)
                            begin
                                found_reg     <= 1'b1;
                                hit_reg       <= rd_idx_reg;
                                hit_count_reg <= rd_count_reg;
                                hit_stamp_reg <= rd_stamp_reg;
                            end
                            if (cur_reg.cmd == CMD_CLEANUP && expired)
                            begin
                                valid_reg[rd_idx_reg] <= 1'b0;
                                used_reg <= used_reg - CW'(1);
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg       <= rd_idx_reg;
                        end
                    end
                end
                ST_APPLY:
                begin
                    res_reg.banned <= (cur_reg.cmd == CMD_CHECK) && found_reg
                        && !hit_expired
                        && ((hit_count_reg == ban_reg) ? (bumped >= ban_reg)
                                                       : (hit_count_reg >= ban_reg));
                    res_reg.present <= found_reg
                        && (cur_reg.cmd inside {CMD_TRACK, CMD_CHECK});
                    res_reg.dropped_full <= (cur_reg.cmd == CMD_TRACK)
                        && !found_reg && !free_found_reg;
                    case (cur_reg.cmd)
                        CMD_TRACK:
                        begin
                            if (!found_reg && free_found_reg)
                            begin
                                valid_reg[free_reg] <= 1'b1;
                                used_reg <= used_reg + CW'(1);
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (found_reg && hit_expired)
                            begin
                                valid_reg[hit_reg] <= 1'b0;
                                used_reg <= used_reg - CW'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            seconds_reg <= seconds_reg + 32'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DONE:
                begin
                    res_reg.entries_in_use <= 7'(used_reg);
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid)
        else $error("result not raised");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("queue popped while busy");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TABLE_DEPTH)) else $error("occupancy overflow");
endmodule

/* tb/offense_count_ban_table_unit_tb.sv */
// Testbench for offense_count_ban_table_unit: drives command transactions,
// predicts each result with a behavioural table model and checks the output.
// Depends on ocbt_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module offense_count_ban_table_unit_tb;
    import ocbt_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [15:0] cfg_data;

    offense_count_ban_table_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // table shadow
    bit          tbl_valid [DEPTH];
    bit [31:0]   tbl_addr  [DEPTH];
    bit [7:0]    tbl_count [DEPTH];
    bit [31:0]   tbl_stamp [DEPTH];
    bit [31:0]   now_secs;
    bit [7:0]    ban_count;
    bit [15:0]   unban_secs;

    ocbt_result_t pending_results[$];
    int          mismatches;
    int          results_seen;
    int          cycles;
    bit          hold_off;
    bit [31:0]   addr_pool[8];

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit aged_out(int s);
        return (now_secs - tbl_stamp[s]) > {16'd0, unban_secs};
    endfunction

    function automatic int lookup(bit [31:0] a);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic ocbt_result_t apply_command(bit [1:0] cmd, bit [31:0] a);
        ocbt_result_t r;
        int s;
        int n;
        r = '0;
        n = 0;
        case (cmd)
            CMD_TRACK:
            begin
                s = lookup(a);
                if (s >= 0)
                begin
                    r.present = 1'b1;
                    if (tbl_count[s] != 8'hFF)
                        tbl_count[s]++;
                    tbl_stamp[s] = now_secs;
                end
                else
                begin
                    s = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i] && s < 0)
                            s = i;
                    if (s >= 0)
                    begin
                        tbl_valid[s] = 1'b1;
                        tbl_addr[s] = a;
                        tbl_count[s] = 8'd1;
                        tbl_stamp[s] = now_secs;
                    end
                    else
                        r.dropped_full = 1'b1;
                end
            end
            CMD_CHECK:
            begin
                s = lookup(a);
                if (s >= 0)
                begin
                    r.present = 1'b1;
                    if (aged_out(s))
                        tbl_valid[s] = 1'b0;
                    else
                    begin
                        if (tbl_count[s] == ban_count)
                        begin
                            if (tbl_count[s] != 8'hFF)
                                tbl_count[s]++;
                            tbl_stamp[s] = now_secs;
                        end
                        r.banned = tbl_count[s] >= ban_count;
                    end
                end
            end
            CMD_TICK:
                now_secs++;
            default:
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && aged_out(i))
                        tbl_valid[i] = 1'b0;
        endcase
        for (int i = 0; i < DEPTH; i++)
            n += tbl_valid[i];
        r.entries_in_use = n[6:0];
        return r;
    endfunction

    // sender: one transaction
    task automatic send_command(bit [1:0] cmd, bit [31:0] a, bit gaps = 1'b1);
        int gap;
        if (gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata = {6'd0, a, cmd};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_command(cmd, a));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * DEPTH + 20) @(negedge clk);
    endtask

    task automatic write_reg(bit [0:0] idx, bit [15:0] val);
        cfg_idx = idx;
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_COUNT_TO_BAN)
            ban_count = val[7:0];
        else
            unban_secs = val;
    endtask

    // receiver
    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        ocbt_result_t got;
        ocbt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.banned         = m_axis_tdata[0];
            got.present        = m_axis_tdata[1];
            got.dropped_full   = m_axis_tdata[2];
            got.entries_in_use = m_axis_tdata[9:3];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want || m_axis_tdata[15:10] !== 6'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected b%0d p%0d d%0d n%0d, got b%0d p%0d d%0d n%0d",
                                 want.banned, want.present, want.dropped_full,
                                 want.entries_in_use, got.banned, got.present,
                                 got.dropped_full, got.entries_in_use);
                end
            end
        end
    end

    task automatic test_directed();
        send_command(CMD_CHECK, 32'h0);
        send_command(CMD_TRACK, 32'h0);
        send_command(CMD_TRACK, 32'hFFFF_FFFF);
        send_command(CMD_TRACK, 32'hFFFF_FFFF);
        send_command(CMD_CHECK, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'hA5A5_5A5A);
        send_command(CMD_CLEANUP, 32'h5A5A_A5A5);
        send_command(CMD_CHECK, 32'h0);
        wait_idle();
        write_reg(REG_COUNT_TO_BAN, 16'd2);
        write_reg(REG_SECONDS_TO_UNBAN, 16'd0);
        send_command(CMD_CHECK, 32'hFFFF_FFFF);   // aged out under a zero unban time: removed
        send_command(CMD_CHECK, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'h0);
        send_command(CMD_TRACK, 32'h0);           // stale entry still bumped
        send_command(CMD_CHECK, 32'hFFFF_FFFF);   // already removed, not present
        send_command(CMD_TICK, 32'h0);
        send_command(CMD_CLEANUP, 32'h0);
        wait_idle();
        write_reg(REG_COUNT_TO_BAN, 16'd0);
        send_command(CMD_TRACK, 32'h1234_5678);
        send_command(CMD_CHECK, 32'h1234_5678);   // zero ban count
        wait_idle();
    endtask

    task automatic test_saturation();
        wait_idle();
        write_reg(REG_COUNT_TO_BAN, 16'd255);
        write_reg(REG_SECONDS_TO_UNBAN, 16'hFFFF);
        for (int i = 0; i < 260; i++)
            send_command(CMD_TRACK, 32'hDEAD_BEEF, 1'b0);
        send_command(CMD_CHECK, 32'hDEAD_BEEF);
        send_command(CMD_CHECK, 32'hDEAD_BEEF);
    endtask

    task automatic test_fill_and_stall();
        fork
        begin
            hold_off = 1'b1;
            repeat (600) @(negedge clk);
            hold_off = 1'b0;
        end
        for (int i = 0; i < DEPTH + 4; i++)
            send_command(CMD_TRACK, {8'($urandom_range(0, 255)), 24'h00_0000} ^ 32'(i),
                         1'b0);
        join
        send_command(CMD_CHECK, 32'hDEAD_BEEF);
        wait_idle();
        write_reg(REG_SECONDS_TO_UNBAN, 16'd1);
        send_command(CMD_TICK, 32'h0);
        send_command(CMD_TICK, 32'h0);
        send_command(CMD_CLEANUP, 32'h0);
        wait_idle();
    endtask

    task automatic test_random(int count);
        bit [31:0] a;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                wait_idle();
                write_reg(REG_COUNT_TO_BAN, 16'($urandom_range(1, 6)));
                write_reg(REG_SECONDS_TO_UNBAN, 16'($urandom_range(0, 12)));
                for (int k = 0; k < 8; k++)
                    addr_pool[k] = $urandom;
            end
            a = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_command(CMD_TRACK, a);
            else if (pick < 80)
                send_command(CMD_CHECK, a);
            else if (pick < 95)
                send_command(CMD_TICK, $urandom);
            else
                send_command(CMD_CLEANUP, $urandom);
        end
    endtask

    task automatic test_time_wrap();
        wait_idle();
        write_reg(REG_SECONDS_TO_UNBAN, 16'd3);
        // entry checked one second past its expiry
        send_command(CMD_TRACK, 32'h0BAD_F00D);
        repeat (4) send_command(CMD_TICK, 32'h0, 1'b0);
        send_command(CMD_CHECK, 32'h0BAD_F00D);
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        now_secs = '0;
        ban_count = 8'd10;
        unban_secs = 16'd300;
        for (int i = 0; i < DEPTH; i++)
            tbl_valid[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_saturation();
        test_fill_and_stall();
        test_time_wrap();
        test_random(540);
        wait_idle();

        $display("Covered track, check, tick and cleanup with full table, saturation,");
        $display("expiry and a long output stall; %0d results checked, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* offense_count_ban_table_unit.f */
rtl/ocbt_pkg.sv
rtl/ocbt_front.sv
rtl/ocbt_back.sv
rtl/offense_count_ban_table_unit.sv
tb/offense_count_ban_table_unit_tb.sv
